### src/aclp_pkg.sv
// package for the ascii command line parser
// constants, phase codes and command kinds; no dependencies
package aclp_pkg;

  localparam int MaxLineChars = 32;
  localparam int PosW = $clog2(MaxLineChars + 1);

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChM     = 8'h4D;
  localparam logic [7:0] ChV     = 8'h56;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChI     = 8'h49;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChG     = 8'h47;
  localparam logic [7:0] ChR     = 8'h52;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;

  localparam logic [3:0] PhStart   = 4'd0;
  localparam logic [3:0] PhFixed   = 4'd1;
  localparam logic [3:0] PhMWant   = 4'd2;
  localparam logic [3:0] PhVlFirst = 4'd3;
  localparam logic [3:0] PhVlWs    = 4'd4;
  localparam logic [3:0] PhVlNum   = 4'd5;
  localparam logic [3:0] PhVrWs    = 4'd6;
  localparam logic [3:0] PhVrNum   = 4'd7;
  localparam logic [3:0] PhRWs     = 4'd8;
  localparam logic [3:0] PhRNum    = 4'd9;
  localparam logic [3:0] PhCFirst  = 4'd10;
  localparam logic [3:0] PhCWs     = 4'd11;
  localparam logic [3:0] PhCInt    = 4'd12;
  localparam logic [3:0] PhCFrac   = 4'd13;

  localparam logic [2:0] KindMode    = 3'd0;
  localparam logic [2:0] KindSpeed   = 3'd1;
  localparam logic [2:0] KindCoef    = 3'd2;
  localparam logic [2:0] KindGet     = 3'd3;
  localparam logic [2:0] KindRate    = 3'd4;
  localparam logic [2:0] KindInvalid = 3'd5;

  localparam logic [0:0] RegFloor = 1'd0;
  localparam logic [0:0] RegCeil  = 1'd1;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         cmd_kind;
    logic               drive_mode;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [1:0]         gain_select;
    logic signed [31:0] gain_mantissa;
    logic [4:0]         gain_decimals;
    logic [15:0]        rate_ms;
  } out_word_t;

  // mag * 10 + digit, saturating at cap
  function automatic logic [31:0] push_digit(input logic [31:0] mag,
                                             input logic [7:0] c,
                                             input logic [31:0] cap);
    logic [35:0] t;
    t = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {32'd0, c[3:0]};
    return (t > {4'd0, cap}) ? cap : t[31:0];
  endfunction

endpackage

### src/aclp_if.sv
// valid/ready channel carrying one word
// depends on nothing
interface aclp_if #(type T = logic [7:0]);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/aclp_core.sv
// per-byte parse state machine and line result builder
// depends on aclp_pkg
module aclp_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              c,
  input  logic signed [15:0]      speed_floor,
  input  logic signed [15:0]      speed_ceiling,
  output logic                    res_valid,
  output aclp_pkg::out_word_t     res
);
  import aclp_pkg::*;

  logic [PosW-1:0]    line_position;
  logic [7:0]         header_char;
  logic [3:0]         parse_phase;
  logic               text_ended;
  logic [31:0]        number_magnitude;
  logic               number_negative;
  logic               digits_seen;
  logic [15:0]        held_left_speed;
  logic [4:0]         fraction_count;
  logic [2:0]         line_verdict;

  logic [PosW-1:0]    line_position_next;
  logic [7:0]         header_char_next;
  logic [3:0]         parse_phase_next;
  logic               text_ended_next;
  logic [31:0]        number_magnitude_next;
  logic               number_negative_next;
  logic               digits_seen_next;
  logic [15:0]        held_left_speed_next;
  logic [4:0]         fraction_count_next;
  logic [2:0]         line_verdict_next;

  logic               is_blank, is_digit, is_sign;
  logic [31:0]        push_full, push_half;
  logic [35:0]        frac_t;
  logic [15:0]        limited;
  logic signed [33:0] sval;
  logic [2:0]         kind;
  logic               emit;
  out_word_t          res_next;

  assign is_blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
  assign is_digit = (c >= ChZero) && (c <= 8'h39);
  assign is_sign  = (c == ChPlus) || (c == ChMinus);
  assign push_full = push_digit(number_magnitude, c, 32'hFFFF_FFFF);
  assign push_half = push_digit(number_magnitude, c, 32'h7FFF_FFFF);
  assign frac_t = {1'b0, number_magnitude, 3'b000} + {3'b000, number_magnitude, 1'b0}
                + {32'd0, c[3:0]};

  // clamp of the current number to the configured range
  always_comb begin
    sval = number_negative ? -$signed({2'b00, number_magnitude})
                           : $signed({2'b00, number_magnitude});
    if (sval < 34'(speed_floor)) limited = speed_floor;
    else if (sval > 34'(speed_ceiling)) limited = speed_ceiling;
    else limited = sval[15:0];
  end

  // next state for one byte
  always_comb begin
    line_position_next    = line_position;
    header_char_next      = header_char;
    parse_phase_next      = parse_phase;
    text_ended_next       = text_ended;
    number_magnitude_next = number_magnitude;
    number_negative_next  = number_negative;
    digits_seen_next      = digits_seen;
    held_left_speed_next  = held_left_speed;
    fraction_count_next   = fraction_count;
    line_verdict_next     = line_verdict;
    if (c == ChLf) begin
      line_position_next    = '0;
      header_char_next      = '0;
      parse_phase_next      = PhStart;
      text_ended_next       = 1'b0;
      number_magnitude_next = '0;
      number_negative_next  = 1'b0;
      digits_seen_next      = 1'b0;
      held_left_speed_next  = '0;
      fraction_count_next   = '0;
      line_verdict_next     = '0;
    end else if (c != ChCr && line_position < PosW'(MaxLineChars)) begin
      line_position_next = line_position + 1'b1;
      if (text_ended || c == ChNul) begin
        text_ended_next = 1'b1;
      end else begin
        case (parse_phase)
          PhStart: begin
            header_char_next = c;
            if (c == ChM) parse_phase_next = PhMWant;
            else if (c == ChV) parse_phase_next = PhVlFirst;
            else if (c == ChP || c == ChI || c == ChD) parse_phase_next = PhCFirst;
            else if (c == ChR) parse_phase_next = PhRWs;
            else begin
              parse_phase_next  = PhFixed;
              line_verdict_next = (c == ChG) ? KindGet : KindInvalid;
            end
          end
          PhMWant: begin
            parse_phase_next = PhFixed;
            if (c == ChZero || c == ChOne) begin
              number_magnitude_next = {31'd0, c[0]};
              line_verdict_next     = KindMode;
            end else begin
              line_verdict_next = KindInvalid;
            end
          end
          PhVlFirst, PhVlWs, PhVrWs, PhRWs: begin
            if (parse_phase == PhVlFirst && c == ChComma) begin
              held_left_speed_next  = limited;
              number_magnitude_next = '0;
              number_negative_next  = 1'b0;
              digits_seen_next      = 1'b0;
              fraction_count_next   = '0;
              parse_phase_next      = PhVrWs;
            end else begin
              if (parse_phase == PhVlFirst) parse_phase_next = PhVlWs;
              if (is_blank) begin
              end else if (is_sign || is_digit) begin
                if (is_sign) number_negative_next = (c == ChMinus);
                else begin
                  number_magnitude_next = push_full;
                  digits_seen_next      = 1'b1;
                end
                parse_phase_next = (parse_phase == PhRWs) ? PhRNum :
                                   (parse_phase == PhVrWs) ? PhVrNum : PhVlNum;
              end else begin
                parse_phase_next  = PhFixed;
                line_verdict_next = KindInvalid;
              end
            end
          end
          PhVlNum: begin
            if (is_digit) begin
              number_magnitude_next = push_full;
              digits_seen_next      = 1'b1;
            end else if (c == ChComma && digits_seen) begin
              held_left_speed_next  = limited;
              number_magnitude_next = '0;
              number_negative_next  = 1'b0;
              digits_seen_next      = 1'b0;
              fraction_count_next   = '0;
              parse_phase_next      = PhVrWs;
            end else begin
              parse_phase_next  = PhFixed;
              line_verdict_next = KindInvalid;
            end
          end
          PhVrNum, PhRNum: begin
            if (is_digit) begin
              number_magnitude_next = push_full;
              digits_seen_next      = 1'b1;
            end else begin
              parse_phase_next  = PhFixed;
              line_verdict_next = !digits_seen ? KindInvalid :
                                  (parse_phase == PhVrNum) ? KindSpeed : KindRate;
            end
          end
          PhCFirst, PhCWs: begin
            parse_phase_next = PhCWs;
            if (is_blank) begin
            end else if (is_sign) begin
              number_negative_next = (c == ChMinus);
              parse_phase_next     = PhCInt;
            end else if (is_digit) begin
              number_magnitude_next = push_half;
              parse_phase_next      = PhCInt;
            end else if (c == ChDot) begin
              parse_phase_next = PhCFrac;
            end else begin
              parse_phase_next  = PhFixed;
              line_verdict_next = KindCoef;
            end
          end
          PhCInt: begin
            if (is_digit) number_magnitude_next = push_half;
            else if (c == ChDot) parse_phase_next = PhCFrac;
            else begin
              parse_phase_next  = PhFixed;
              line_verdict_next = KindCoef;
            end
          end
          PhCFrac: begin
            if (is_digit) begin
              if (fraction_count < 5'd31 && frac_t <= 36'h0_7FFF_FFFF) begin
                number_magnitude_next = frac_t[31:0];
                fraction_count_next   = fraction_count + 1'b1;
              end
            end else begin
              parse_phase_next  = PhFixed;
              line_verdict_next = KindCoef;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result of a closing line
  always_comb begin
    emit = 1'b1;
    case (parse_phase)
      PhStart: begin
        emit = 1'b0;
        kind = KindInvalid;
      end
      PhFixed: kind = line_verdict;
      PhVrNum: kind = digits_seen ? KindSpeed : KindInvalid;
      PhRNum:  kind = digits_seen ? KindRate : KindInvalid;
      PhCWs, PhCInt, PhCFrac: kind = KindCoef;
      default: kind = KindInvalid;
    endcase
    res_next = '0;
    res_next.cmd_kind = kind;
    if (kind == KindMode) res_next.drive_mode = number_magnitude[0];
    if (kind == KindSpeed) begin
      res_next.left_speed  = held_left_speed;
      res_next.right_speed = limited;
    end
    if (kind == KindCoef) begin
      res_next.gain_select   = (header_char == ChP) ? 2'd0 : (header_char == ChI) ? 2'd1 : 2'd2;
      res_next.gain_mantissa = number_negative ? -number_magnitude : number_magnitude;
      res_next.gain_decimals = fraction_count;
    end
    if (kind == KindRate) res_next.rate_ms = number_negative ? 16'd0 : number_magnitude[15:0];
  end

  // parse state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position    <= '0;
      header_char      <= '0;
      parse_phase      <= PhStart;
      text_ended       <= 1'b0;
      number_magnitude <= '0;
      number_negative  <= 1'b0;
      digits_seen      <= 1'b0;
      held_left_speed  <= '0;
      fraction_count   <= '0;
      line_verdict     <= '0;
      res_valid        <= 1'b0;
    end else if (step) begin
      line_position    <= line_position_next;
      header_char      <= header_char_next;
      parse_phase      <= parse_phase_next;
      text_ended       <= text_ended_next;
      number_magnitude <= number_magnitude_next;
      number_negative  <= number_negative_next;
      digits_seen      <= digits_seen_next;
      held_left_speed  <= held_left_speed_next;
      fraction_count   <= fraction_count_next;
      line_verdict     <= line_verdict_next;
      res_valid        <= (c == ChLf) && emit;
    end else begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res <= res_next;
  end

`ifndef SYNTH
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    line_position <= PosW'(MaxLineChars)) else $error("line position past limit");
  a_lf_clears: assert property (@(posedge clk) disable iff (rst)
    step && c == ChLf |=> parse_phase == PhStart && line_position == '0)
    else $error("line state not cleared on lf");
  a_res_only_lf: assert property (@(posedge clk) disable iff (rst)
    !(step && c == ChLf) |=> !res_valid) else $error("result without lf");
  a_frac_bound: assert property (@(posedge clk) disable iff (rst)
    fraction_count != 5'd0 |-> parse_phase == PhCFrac || parse_phase == PhFixed)
    else $error("fraction count outside coefficient");
`endif
endmodule

### src/ascii_command_line_parser.sv
// top level of the ascii command line parser
// depends on aclp_pkg, aclp_if and aclp_core
//
//  channel   dir   word                    handshake
//  in_ch     in    rx_byte (8)             valid/ready
//  out_ch    out   command fields          valid/ready
//  cfg       in    index (1), data (16)    write enable
//
// one byte per cycle while input ready is high; a result passes the core result register,
// then the output queue, after the lf that closes its line is taken. synchronous reset
// clears the line state and sets floor -255, ceiling 255. a two-entry queue on the
// output holds results; input ready drops while both entries are full, or while
// one is full and a new result is landing.
module ascii_command_line_parser (
  input  logic        clk,
  input  logic        rst,
  aclp_if.sink        in_ch,
  aclp_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import aclp_pkg::*;

  logic signed [15:0] speed_floor;
  logic signed [15:0] speed_ceiling;
  logic               step;
  logic               res_valid;
  out_word_t          res;
  out_word_t          buf0, buf1;
  logic [1:0]         count;
  logic               pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_floor   <= -16'sd255;
      speed_ceiling <= 16'sd255;
    end else if (cfg_we) begin
      case (cfg_index)
        RegFloor: speed_floor   <= cfg_data;
        RegCeil:  speed_ceiling <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // a result can land while two are queued only if ready was high, so keep room
  assign in_ch.ready = (count == 2'd0) || (count == 2'd1) && !res_valid;
  assign step = in_ch.valid && in_ch.ready;

  aclp_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .c             (in_ch.data.rx_byte),
    .speed_floor   (speed_floor),
    .speed_ceiling (speed_ceiling),
    .res_valid     (res_valid),
    .res           (res)
  );

  // two-word output queue
  assign out_ch.valid = count != 2'd0;
  assign out_ch.data  = buf0;
  assign pop = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else count <= count + {1'b0, res_valid} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buf0 <= (count == 2'd2) ? buf1 : res;
      if (res_valid) buf1 <= res;
    end else if (res_valid) begin
      if (count == 2'd0) buf0 <= res;
      else buf1 <= res;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("output queue overflow");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !in_ch.ready) else $error("input taken with queue full");
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> count + {1'b0, res_valid} <= 2'd1) else $error("no room behind ready");
`endif
endmodule

### tb/tb_top.sv
// testbench for the ascii command line parser: random and directed text lines,
// a scoreboard class with its own command decoder, random stalls on both sides
// depends on aclp_pkg, aclp_if and ascii_command_line_parser
`timescale 1ns / 1ps

module tb_top;
  import aclp_pkg::*;

  typedef logic [7:0] text_q_t[$];

  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam int StallLimit = 5000;
  localparam int DrainCycles = 8;
  localparam int BytesPerPhase = 270;

  // decoder of text lines into expected commands
  class command_scoreboard;
    out_word_t cmd_q[$];
    int errors;
    logic signed [15:0] floor_r, ceil_r;
    logic [5:0]  pos;
    logic [7:0]  hdr;
    logic [3:0]  ph;
    logic        ended;
    logic [31:0] mag;
    logic        neg;
    logic        digs;
    logic [15:0] held;
    logic [4:0]  frac;
    logic [2:0]  verdict;

    function new();
      errors = 0;
      floor_r = -16'sd255;
      ceil_r = 16'sd255;
      clear_line();
    endfunction

    function void clear_number();
      mag = '0;
      neg = 1'b0;
      digs = 1'b0;
      frac = '0;
    endfunction

    function void clear_line();
      pos = '0;
      hdr = '0;
      ph = PhStart;
      ended = 1'b0;
      held = '0;
      verdict = '0;
      clear_number();
    endfunction

    function void set_reg(logic [0:0] idx, logic [15:0] val);
      if (idx == RegFloor) floor_r = val;
      else ceil_r = val;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == ChSpace || c == ChTab || c == ChVt || c == ChFf;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= ChZero && c <= ChNine;
    endfunction

    function logic [31:0] add_digit(logic [31:0] m, logic [7:0] c, logic [31:0] cap);
      logic [63:0] t;
      t = {32'd0, m} * 64'd10 + {56'd0, c - ChZero};
      return (t > {32'd0, cap}) ? cap : t[31:0];
    endfunction

    function logic [15:0] fit_speed();
      logic signed [33:0] v;
      v = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      if (v < floor_r) return floor_r;
      if (v > ceil_r) return ceil_r;
      return v[15:0];
    endfunction

    function void settle(logic [2:0] kind);
      ph = PhFixed;
      verdict = kind;
    endfunction

    // blank, sign or first digit of an integer
    function void int_start(logic [7:0] c, logic [3:0] nxt);
      if (is_blank(c)) return;
      if (c == ChPlus || c == ChMinus) begin
        neg = (c == ChMinus);
        ph = nxt;
      end else if (is_digit(c)) begin
        mag = add_digit(mag, c, 32'hFFFF_FFFF);
        digs = 1'b1;
        ph = nxt;
      end else begin
        settle(KindInvalid);
      end
    endfunction

    function void take_char(logic [7:0] c);
      logic [63:0] t;
      case (ph)
        PhStart: begin
          hdr = c;
          if (c == ChM) ph = PhMWant;
          else if (c == ChV) ph = PhVlFirst;
          else if (c == ChP || c == ChI || c == ChD) ph = PhCFirst;
          else if (c == ChG) settle(KindGet);
          else if (c == ChR) ph = PhRWs;
          else settle(KindInvalid);
        end
        PhMWant: begin
          if (c == ChZero || c == ChOne) begin
            mag = {31'd0, c[0]};
            settle(KindMode);
          end else begin
            settle(KindInvalid);
          end
        end
        PhVlFirst: begin
          if (c == ChComma) begin
            held = fit_speed();
            clear_number();
            ph = PhVrWs;
          end else begin
            ph = PhVlWs;
            int_start(c, PhVlNum);
          end
        end
        PhVlWs: int_start(c, PhVlNum);
        PhVlNum: begin
          if (is_digit(c)) begin
            mag = add_digit(mag, c, 32'hFFFF_FFFF);
            digs = 1'b1;
          end else if (c == ChComma && digs) begin
            held = fit_speed();
            clear_number();
            ph = PhVrWs;
          end else begin
            settle(KindInvalid);
          end
        end
        PhVrWs: int_start(c, PhVrNum);
        PhRWs: int_start(c, PhRNum);
        PhVrNum, PhRNum: begin
          if (is_digit(c)) begin
            mag = add_digit(mag, c, 32'hFFFF_FFFF);
            digs = 1'b1;
          end else if (!digs) begin
            settle(KindInvalid);
          end else begin
            settle(ph == PhVrNum ? KindSpeed : KindRate);
          end
        end
        PhCFirst, PhCWs: begin
          ph = PhCWs;
          if (!is_blank(c)) begin
            if (c == ChPlus || c == ChMinus) begin
              neg = (c == ChMinus);
              ph = PhCInt;
            end else if (is_digit(c)) begin
              mag = add_digit(mag, c, 32'h7FFF_FFFF);
              ph = PhCInt;
            end else if (c == ChDot) begin
              ph = PhCFrac;
            end else begin
              settle(KindCoef);
            end
          end
        end
        PhCInt: begin
          if (is_digit(c)) mag = add_digit(mag, c, 32'h7FFF_FFFF);
          else if (c == ChDot) ph = PhCFrac;
          else settle(KindCoef);
        end
        PhCFrac: begin
          if (is_digit(c)) begin
            t = {32'd0, mag} * 64'd10 + {56'd0, c - ChZero};
            if (frac < 5'd31 && t <= 64'h7FFF_FFFF) begin
              mag = t[31:0];
              frac = frac + 5'd1;
            end
          end else begin
            settle(KindCoef);
          end
        end
        default: ;
      endcase
    endfunction

    // line closed: work out the command, if any
    function void close_line();
      out_word_t w;
      logic [2:0] kind;
      w = '0;
      case (ph)
        PhStart: return;
        PhFixed: kind = verdict;
        PhVrNum: kind = digs ? KindSpeed : KindInvalid;
        PhRNum: kind = digs ? KindRate : KindInvalid;
        PhCWs, PhCInt, PhCFrac: kind = KindCoef;
        default: kind = KindInvalid;
      endcase
      w.cmd_kind = kind;
      if (kind == KindMode) begin
        w.drive_mode = mag[0];
      end else if (kind == KindSpeed) begin
        w.left_speed = held;
        w.right_speed = fit_speed();
      end else if (kind == KindCoef) begin
        w.gain_select = (hdr == ChP) ? 2'd0 : (hdr == ChI) ? 2'd1 : 2'd2;
        w.gain_mantissa = neg ? -mag : mag;
        w.gain_decimals = frac;
      end else if (kind == KindRate) begin
        w.rate_ms = neg ? 16'd0 : mag[15:0];
      end
      cmd_q.push_back(w);
    endfunction

    // accepted input word
    function void note_byte(logic [7:0] c);
      if (c == ChCr) return;
      if (c == ChLf) begin
        close_line();
        clear_line();
        return;
      end
      if (pos < MaxLineChars) begin
        pos = pos + 6'd1;
        if (ended || c == ChNul) ended = 1'b1;
        else take_char(c);
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
    endtask

    // accepted output word
    task check(out_word_t got);
      out_word_t w;
      if (cmd_q.size() == 0) begin
        report("unexpected command, kind", got.cmd_kind, 0);
        return;
      end
      w = cmd_q.pop_front();
      if (got.cmd_kind != w.cmd_kind) report("cmd_kind", got.cmd_kind, w.cmd_kind);
      if (got.drive_mode != w.drive_mode) report("drive_mode", got.drive_mode, w.drive_mode);
      if (got.left_speed != w.left_speed) report("left_speed", got.left_speed, w.left_speed);
      if (got.right_speed != w.right_speed)
        report("right_speed", got.right_speed, w.right_speed);
      if (got.gain_select != w.gain_select)
        report("gain_select", got.gain_select, w.gain_select);
      if (got.gain_mantissa != w.gain_mantissa)
        report("gain_mantissa", got.gain_mantissa, w.gain_mantissa);
      if (got.gain_decimals != w.gain_decimals)
        report("gain_decimals", got.gain_decimals, w.gain_decimals);
      if (got.rate_ms != w.rate_ms) report("rate_ms", got.rate_ms, w.rate_ms);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_fire, out_fire;
  out_word_t   out_seen;
  int          tx_idle, rx_idle;
  int          bytes_sent;
  int          stall_count;
  command_scoreboard sb;

  aclp_if #(.T(in_word_t)) in_ch ();
  aclp_if #(.T(out_word_t)) out_ch ();

  ascii_command_line_parser i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // handshakes sampled mid-cycle, when all signals are settled
  always @(negedge clk) begin
    in_fire = !rst && in_ch.valid && in_ch.ready;
    out_fire = !rst && out_ch.valid && out_ch.ready;
    out_seen = out_ch.data;
  end

  // receiver: check accepted words, stall at random
  always @(posedge clk) begin
    if (out_fire) sb.check(out_seen);
    out_ch.ready <= ($urandom_range(99) >= rx_idle);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || in_fire || out_fire) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= b;
    do @(posedge clk); while (!in_fire);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_line(text_q_t q);
    foreach (q[i]) send_byte(q[i]);
    send_byte(ChLf);
  endtask

  // wait for every command, then let the block settle before a write
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.cmd_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [7:0] rand_digit();
    return ChZero + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(3))
      0: return ChSpace;
      1: return ChTab;
      2: return ChVt;
      default: return ChFf;
    endcase
  endfunction

  function automatic void add_junk(ref text_q_t q);
    repeat ($urandom_range(3)) q.push_back(8'($urandom_range(32, 126)));
  endfunction

  // strtol style integer, mostly short, sometimes long enough to saturate
  function automatic void add_int(ref text_q_t q);
    int nd;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) q.push_back(rand_blank());
    case ($urandom_range(3))
      0: q.push_back(ChMinus);
      1: q.push_back(ChPlus);
      default: ;
    endcase
    nd = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
    if ($urandom_range(9) == 0) nd = 0;
    else if (nd == 0) nd = 1;
    repeat (nd) q.push_back(rand_digit());
  endfunction

  function automatic text_q_t build_line();
    text_q_t q;
    int k;
    case ($urandom_range(9))
      0: begin
        q.push_back(ChM);
        case ($urandom_range(2))
          0: q.push_back(ChZero);
          1: q.push_back(ChOne);
          default: q.push_back(8'($urandom_range(32, 126)));
        endcase
        add_junk(q);
      end
      1, 2: begin
        q.push_back(ChV);
        if ($urandom_range(5) != 0) add_int(q);
        q.push_back(ChComma);
        add_int(q);
        add_junk(q);
      end
      3, 4: begin
        case ($urandom_range(2))
          0: q.push_back(ChP);
          1: q.push_back(ChI);
          default: q.push_back(ChD);
        endcase
        if ($urandom_range(3) == 0) q.push_back(rand_blank());
        if ($urandom_range(2) == 0) q.push_back($urandom_range(1) ? ChMinus : ChPlus);
        repeat ($urandom_range(0, 11)) q.push_back(rand_digit());
        if ($urandom_range(3) != 0) begin
          q.push_back(ChDot);
          repeat ($urandom_range(0, 14)) q.push_back(rand_digit());
        end
        if ($urandom_range(4) == 0) add_junk(q);
      end
      5: begin
        q.push_back(ChG);
        add_junk(q);
      end
      6, 7: begin
        q.push_back(ChR);
        add_int(q);
        if ($urandom_range(3) == 0) add_junk(q);
      end
      8: repeat ($urandom_range(0, 12)) q.push_back(8'($urandom_range(255)));
      default: begin
        // long line: numbers that may be cut by the line limit
        q.push_back(ChR);
        repeat ($urandom_range(28, 40)) q.push_back(rand_digit());
      end
    endcase
    // broken variants: stray nul, cr, or one corrupted byte
    if (q.size() > 0 && $urandom_range(9) == 0) q.insert($urandom_range(q.size() - 1), ChNul);
    if ($urandom_range(7) == 0) q.insert($urandom_range(q.size()), ChCr);
    if (q.size() > 0 && $urandom_range(14) == 0) begin
      k = $urandom_range(q.size() - 1);
      q[k] = 8'($urandom_range(255));
    end
    return q;
  endfunction

  function automatic text_q_t str_bytes(string s);
    text_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // directed lines: every command, extremes and corner cases
  task automatic send_directed();
    string lines[$];
    text_q_t q;
    lines = '{"M0", "M1", "M7", "V100,-100", "V,5", "V-300,300", "V5,", "V 12 ,3",
              "V-99999999999,+4294967296", "P1.5", "I-0.25", "D", "Dx", "P.",
              "I99999999999.9", "G junk", "R-5", "R70000", "R+4294967299", "R",
              "X", ""};
    foreach (lines[i]) send_line(str_bytes(lines[i]));
    q = str_bytes("M1");
    q.insert(0, ChNul);
    send_line(q);
    q = str_bytes("G");
    q.push_back(ChCr);
    send_line(q);
    q = str_bytes("R12");
    q.insert(2, ChNul);
    send_line(q);
    send_byte(ChCr);
    send_byte(ChLf);
    q = str_bytes("P");
    repeat (40) q.push_back(ChOne);
    send_line(q);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = RegFloor;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    in_fire = 1'b0;
    out_fire = 1'b0;
    tx_idle = 36;
    rx_idle = 87;
    bytes_sent = 0;
    stall_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part with the reset limits
    send_directed();

    for (int p = 0; p < 3; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_reg(RegFloor, 16'h8000);
          write_reg(RegCeil, 16'h7FFF);
        end
        1: begin
          tx_idle = 87;
          rx_idle = 36;
          write_reg(RegFloor, 16'($urandom_range(65535)));
          write_reg(RegCeil, 16'($urandom_range(65535)));
        end
        default: begin
          // floor above ceiling
          tx_idle = 0;
          rx_idle = 0;
          write_reg(RegFloor, 16'h7FFF);
          write_reg(RegCeil, 16'h8000);
        end
      endcase
      while (bytes_sent < (p + 1) * BytesPerPhase + 200) send_line(build_line());
    end

    in_ch.valid <= 1'b0;
    while (sb.cmd_q.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
src/aclp_pkg.sv
src/aclp_if.sv
src/aclp_core.sv
src/ascii_command_line_parser.sv
tb/tb_top.sv
